### rtl/core/dsp_pkg.sv
package dsp_pkg;

  // Number of disks tracked; the device field is fixed at 4 bits
  localparam int unsigned NUM_DEVICES = 16;
  localparam int unsigned DEV_W       = 4;

  localparam logic [31:0] HOUR_SECS = 32'd3600;
  localparam int unsigned MB_SHIFT  = 20;

  // Configuration register indexes
  localparam logic [2:0] CFG_DELAY   = 3'd0;
  localparam logic [2:0] CFG_MIN_WB  = 3'd1;
  localparam logic [2:0] CFG_MAX_CYC = 3'd2;
  localparam logic [2:0] CFG_RATE    = 3'd3;
  localparam logic [2:0] CFG_DRY_RUN = 3'd4;

  // Configuration reset values
  localparam logic [31:0] RST_DELAY   = 32'd300;
  localparam logic [31:0] RST_MIN_WB  = 32'd64;
  localparam logic [15:0] RST_MAX_CYC = 16'd4;

  // Action codes
  localparam logic [2:0] ACT_SKIP     = 3'd0;
  localparam logic [2:0] ACT_SPINDOWN = 3'd1;
  localparam logic [2:0] ACT_WB_SPIN  = 3'd2;
  localparam logic [2:0] ACT_IDLE     = 3'd3;
  localparam logic [2:0] ACT_FLUSH    = 3'd4;
  localparam logic [2:0] ACT_DEFER    = 3'd5;
  localparam logic [2:0] ACT_PAUSED   = 3'd6;

  // Writeback control codes
  localparam logic [1:0] WB_NONE = 2'd0;
  localparam logic [1:0] WB_OFF  = 2'd1;
  localparam logic [1:0] WB_ON   = 2'd2;

  // Cache states above this one mean skip
  localparam logic [1:0] CACHE_DIRTY = 2'd1;
  localparam logic [1:0] SPIN_STANDBY = 2'd0;

  typedef struct packed {
    logic [DEV_W-1:0] device;
    logic [31:0]      now_secs;
    logic [63:0]      dirty_size;
    logic [1:0]       cache_state;
    logic             stats_ok;
    logic [63:0]      read_count;
    logic [63:0]      read_sector_count;
    logic [63:0]      write_count;
    logic [63:0]      write_sector_count;
    logic [1:0]       spin_status;
  } in_t;

  typedef struct packed {
    logic [DEV_W-1:0] device_out;
    logic [2:0]       action;
    logic [1:0]       writeback_write;
    logic             issue_spindown;
    logic             set_rate;
    logic [30:0]      idle_time;
    logic [43:0]      dirty_mib;
    logic [15:0]      cycles_used;
  } out_t;

  // One entry of the per-disk state memory
  typedef struct packed {
    logic [63:0] prev_reads;
    logic [63:0] prev_read_sectors;
    logic [63:0] prev_writes;
    logic [63:0] prev_write_sectors;
    logic [31:0] last_activity;
    logic [31:0] window_start;
    logic [15:0] spin_cycles;
  } dstate_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_CALC = 2'b10
  } state_e;

endpackage

### rtl/core/disk_spindown_policy_top.sv
// Disk spin-down policy engine.
// Input channel: one poll beat per disk (in_valid_i / in_stall_o / in_data_i).
// Output channel: exactly one result beat per poll (out_valid_o / out_stall_i /
// out_data_o), in poll order.
// Config port: cfg_we_i writes cfg_wdata_i into register cfg_idx_i; write only
// while no poll is in flight.
// Each poll: the accept edge reads the disk's entry of the state memory into a
// register and moves to the compute state; once the output register is free,
// the compute state computes the decision, writes the entry back and loads the
// output register. No new poll is taken while one is held in the compute state
// (in_stall_o); there is one read-modify-write of the state memory per poll.
// The result beat is valid from the edge that leaves the compute state.
// When the receiver stalls, the result waits in the output register; one more
// poll is taken and then held until the output register frees up.
// Reset clears the seen and counter-valid bits of every disk and restores the
// config defaults; the state memory needs no clearing pass, entries of unseen
// disks are ignored.
module disk_spindown_policy_top import dsp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_t        out_data_o
);

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    sat_inc = (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  // Config registers
  logic [31:0] delay_q, minwb_q, rate_q;
  logic [15:0] maxcyc_q;
  logic        dry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q  <= RST_DELAY;
      minwb_q  <= RST_MIN_WB;
      maxcyc_q <= RST_MAX_CYC;
      rate_q   <= '0;
      dry_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DELAY:   delay_q  <= cfg_wdata_i;
        CFG_MIN_WB:  minwb_q  <= cfg_wdata_i;
        CFG_MAX_CYC: maxcyc_q <= cfg_wdata_i[15:0];
        CFG_RATE:    rate_q   <= cfg_wdata_i;
        CFG_DRY_RUN: dry_q    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Control
  state_e state_q, state_d;
  logic   out_valid_q;
  out_t   out_q;
  in_t    item_q;
  logic   in_acc, advance;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign advance     = (state_q == S_CALC) && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_acc) state_d = S_CALC;
      S_CALC: if (advance) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Per-disk state memory, read at accept, written back on advance
  dstate_t mem [NUM_DEVICES];
  dstate_t rd_q, wr_rec;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_q   <= mem[in_data_i.device];
      item_q <= in_data_i;
    end
  end

  // Valid bits for the memory entries
  logic [NUM_DEVICES-1:0] seen_q, cv_q;
  logic in_range, seen, cv, cv_new;

  assign in_range = 32'(item_q.device) < NUM_DEVICES;
  assign seen     = seen_q[item_q.device];
  assign cv       = cv_q[item_q.device];

  // Decision logic for the held poll
  logic [31:0] la0, la1, la2, la3, ws0, ws1, dw, di, idle;
  logic [15:0] sc0, sc1, sc2;
  logic [43:0] dmb;
  logic        skip, spinning, act_cnt, take_cnt;
  logic [2:0]  action;
  logic [1:0]  wbw;
  logic        issue, setr;

  assign dmb      = item_q.dirty_size[63:MB_SHIFT];
  assign skip     = item_q.cache_state > CACHE_DIRTY;
  assign spinning = item_q.spin_status != SPIN_STANDBY;

  always_comb begin
    // first poll takes the current time
    la0 = seen ? rd_q.last_activity : item_q.now_secs;
    ws0 = seen ? rd_q.window_start : item_q.now_secs;
    sc0 = seen ? rd_q.spin_cycles : 16'd0;

    // activity detect
    act_cnt  = (item_q.read_count != rd_q.prev_reads) ||
               (item_q.read_sector_count != rd_q.prev_read_sectors) ||
               (item_q.write_count != rd_q.prev_writes) ||
               (item_q.write_sector_count != rd_q.prev_write_sectors);
    take_cnt = item_q.stats_ok && (!cv || act_cnt);
    cv_new   = cv || item_q.stats_ok;
    la1      = (item_q.stats_ok && cv && act_cnt) ? item_q.now_secs : la0;

    // hourly window
    dw  = item_q.now_secs - ws0;
    sc1 = sc0;
    ws1 = ws0;
    if (!dw[31] && dw >= HOUR_SECS) begin
      sc1 = '0;
      ws1 = item_q.now_secs;
    end

    // idle time, clamped
    di = item_q.now_secs - la1;
    if (di[31]) begin
      idle = '0;
      la2  = item_q.now_secs;
    end else begin
      idle = di;
      la2  = la1;
    end

    // policy
    action = ACT_SKIP;
    wbw    = WB_NONE;
    issue  = 1'b0;
    setr   = 1'b0;
    la3    = la2;
    sc2    = sc1;
    if (spinning) begin
      if (idle >= delay_q && dmb < {12'd0, minwb_q}) begin
        action = ACT_SPINDOWN;
        wbw    = WB_OFF;
        issue  = !dry_q;
        sc2    = sat_inc(sc1);
      end else if (dmb != '0) begin
        action = ACT_WB_SPIN;
        wbw    = WB_ON;
      end else begin
        action = ACT_IDLE;
      end
    end else if (dmb >= {12'd0, minwb_q}) begin
      if ({16'd0, sc1} >= {16'd0, maxcyc_q}) begin
        action = ACT_DEFER;
      end else begin
        action = ACT_FLUSH;
        wbw    = WB_ON;
        setr   = rate_q != '0;
        la3    = item_q.now_secs;
        sc2    = sat_inc(sc1);
      end
    end else begin
      action = ACT_PAUSED;
      wbw    = WB_OFF;
    end

    // write-back record; skipped polls keep only the first-poll setup
    wr_rec.prev_reads         = take_cnt && !skip ? item_q.read_count : rd_q.prev_reads;
    wr_rec.prev_read_sectors  = take_cnt && !skip ? item_q.read_sector_count
                                                  : rd_q.prev_read_sectors;
    wr_rec.prev_writes        = take_cnt && !skip ? item_q.write_count : rd_q.prev_writes;
    wr_rec.prev_write_sectors = take_cnt && !skip ? item_q.write_sector_count
                                                  : rd_q.prev_write_sectors;
    wr_rec.last_activity      = skip ? la0 : la3;
    wr_rec.window_start       = skip ? ws0 : ws1;
    wr_rec.spin_cycles        = skip ? sc0 : sc2;
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_range) begin
      mem[item_q.device] <= wr_rec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      cv_q   <= '0;
    end else if (advance && in_range) begin
      seen_q[item_q.device] <= 1'b1;
      if (!skip) begin
        cv_q[item_q.device] <= cv_new;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q.device_out <= item_q.device;
      out_q.dirty_mib  <= dmb;
      if (!in_range || skip) begin
        out_q.action          <= ACT_SKIP;
        out_q.writeback_write <= WB_NONE;
        out_q.issue_spindown  <= 1'b0;
        out_q.set_rate        <= 1'b0;
        out_q.idle_time       <= '0;
        out_q.cycles_used     <= in_range ? sc0 : 16'd0;
      end else begin
        out_q.action          <= action;
        out_q.writeback_write <= wbw;
        out_q.issue_spindown  <= issue;
        out_q.set_rate        <= setr;
        out_q.idle_time       <= idle[30:0];
        out_q.cycles_used     <= sc2;
      end
    end
  end

`ifndef SYNTHESIS
  a_acc_to_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_CALC))
    else $error("accepted poll did not enter compute");

  a_issue_act: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.issue_spindown) |-> (out_q.action == ACT_SPINDOWN))
    else $error("spin-down command without spin-down action");

  a_rate_act: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.set_rate) |-> (out_q.action == ACT_FLUSH))
    else $error("rate set without flush action");

  a_adv_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (out_valid_q && state_q == S_IDLE))
    else $error("computed poll did not produce a result");
`endif

endmodule

### tb/disk_spindown_policy_top_tb.sv
module disk_spindown_policy_top_tb;
  import dsp_pkg::*;

  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned HOLD_CYCLES = 48;
  localparam int unsigned PHASES      = 9;
  localparam int unsigned PHASE_POLLS = 145;
  localparam logic [63:0] MB          = 64'd1 << MB_SHIFT;
  localparam logic [63:0] ALL1        = {64{1'b1}};

  typedef struct {
    in_t  poll;
    bit   typed;
    out_t want;
  } row_t;

  logic        clk_i     = 1'b0;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_idx   = '0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid  = 1'b0;
  in_t         in_data   = '0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  out_t        out_data;

  // Policy registers as the block should hold them
  logic [31:0] cf_delay  = RST_DELAY;
  logic [31:0] cf_minwb  = RST_MIN_WB;
  logic [15:0] cf_maxcyc = RST_MAX_CYC;
  logic [31:0] cf_rate   = '0;
  logic        cf_dry    = 1'b0;

  // Per-disk policy state
  bit          dk_seen     [NUM_DEVICES];
  bit          dk_cnt_ok   [NUM_DEVICES];
  logic [63:0] dk_rc       [NUM_DEVICES];
  logic [63:0] dk_rs       [NUM_DEVICES];
  logic [63:0] dk_wc       [NUM_DEVICES];
  logic [63:0] dk_ws       [NUM_DEVICES];
  logic [31:0] dk_last_act [NUM_DEVICES];
  logic [31:0] dk_win      [NUM_DEVICES];
  logic [15:0] dk_cycles   [NUM_DEVICES] = '{default: 16'd0};

  // Random poll generator: per-disk clock and counters
  logic [31:0] rn_now [NUM_DEVICES];
  logic [63:0] rn_cnt [NUM_DEVICES][4];

  out_t        decisions_q [$];
  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;
  bit          calm         = 1'b0;
  int unsigned hold_reqs    = 0;
  int unsigned hold_seen    = 0;
  int unsigned hold_left    = 0;

  disk_spindown_policy_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Spin-down decision for one poll; updates the per-disk state
  function automatic out_t decide_action(in_t p);
    out_t        r;
    logic [63:0] mb;
    logic [31:0] d;
    logic [31:0] idle;
    int unsigned k;
    mb = p.dirty_size >> MB_SHIFT;
    k = 32'(p.device);
    r = '0;
    r.device_out = p.device;
    r.dirty_mib = mb[43:0];
    if (!dk_seen[k]) begin
      dk_seen[k] = 1'b1;
      dk_last_act[k] = p.now_secs;
      dk_win[k] = p.now_secs;
    end
    if (p.cache_state > CACHE_DIRTY) begin
      r.action = ACT_SKIP;
      r.cycles_used = dk_cycles[k];
      return r;
    end
    // activity: any counter moved since the last good read
    if (p.stats_ok) begin
      if (!dk_cnt_ok[k]) begin
        dk_cnt_ok[k] = 1'b1;
        dk_rc[k] = p.read_count;
        dk_rs[k] = p.read_sector_count;
        dk_wc[k] = p.write_count;
        dk_ws[k] = p.write_sector_count;
      end else if ({p.read_count, p.read_sector_count, p.write_count, p.write_sector_count}
                   != {dk_rc[k], dk_rs[k], dk_wc[k], dk_ws[k]}) begin
        dk_last_act[k] = p.now_secs;
        dk_rc[k] = p.read_count;
        dk_rs[k] = p.read_sector_count;
        dk_wc[k] = p.write_count;
        dk_ws[k] = p.write_sector_count;
      end
    end
    // hourly budget window; a window start in the future keeps the budget
    d = p.now_secs - dk_win[k];
    if (!d[31] && d >= HOUR_SECS) begin
      dk_cycles[k] = '0;
      dk_win[k] = p.now_secs;
    end
    // idle time, clock going backwards restarts it
    d = p.now_secs - dk_last_act[k];
    if (d[31]) begin
      idle = '0;
      dk_last_act[k] = p.now_secs;
    end else begin
      idle = d;
    end
    r.idle_time = idle[30:0];
    if (p.spin_status != SPIN_STANDBY) begin
      if (idle >= cf_delay && mb < {32'd0, cf_minwb}) begin
        r.action = ACT_SPINDOWN;
        r.writeback_write = WB_OFF;
        r.issue_spindown = !cf_dry;
        if (dk_cycles[k] != 16'hFFFF) dk_cycles[k]++;
      end else if (mb != '0) begin
        r.action = ACT_WB_SPIN;
        r.writeback_write = WB_ON;
      end else begin
        r.action = ACT_IDLE;
      end
    end else if (mb >= {32'd0, cf_minwb}) begin
      if (dk_cycles[k] >= cf_maxcyc) begin
        r.action = ACT_DEFER;
      end else begin
        r.action = ACT_FLUSH;
        r.writeback_write = WB_ON;
        r.set_rate = (cf_rate != '0);
        dk_last_act[k] = p.now_secs;
        if (dk_cycles[k] != 16'hFFFF) dk_cycles[k]++;
      end
    end else begin
      r.action = ACT_PAUSED;
      r.writeback_write = WB_OFF;
    end
    r.cycles_used = dk_cycles[k];
    return r;
  endfunction

  function automatic in_t poll_of(logic [3:0] dev, logic [31:0] now, logic [63:0] dirty,
                                  logic [1:0] cs, logic sok, logic [63:0] rc,
                                  logic [63:0] rs, logic [63:0] wc, logic [63:0] ws,
                                  logic [1:0] spin);
    in_t p;
    p.device = dev;
    p.now_secs = now;
    p.dirty_size = dirty;
    p.cache_state = cs;
    p.stats_ok = sok;
    p.read_count = rc;
    p.read_sector_count = rs;
    p.write_count = wc;
    p.write_sector_count = ws;
    p.spin_status = spin;
    return p;
  endfunction

  function automatic out_t result_of(logic [3:0] dev, logic [2:0] act, logic [1:0] wb,
                                     logic iss, logic sr, logic [30:0] idle,
                                     logic [43:0] mb, logic [15:0] cyc);
    out_t r;
    r.device_out = dev;
    r.action = act;
    r.writeback_write = wb;
    r.issue_spindown = iss;
    r.set_rate = sr;
    r.idle_time = idle;
    r.dirty_mib = mb;
    r.cycles_used = cyc;
    return r;
  endfunction

  // Mostly plausible polls: a few busy disks, time moving forward, counters
  // that mostly stand still, dirty sizes around the writeback threshold
  function automatic in_t random_poll();
    in_t         p;
    int unsigned k;
    int unsigned pick;
    logic [63:0] edge_mb;
    pick = $urandom_range(0, 99);
    k = (pick < 70) ? $urandom_range(0, 3) : $urandom_range(0, NUM_DEVICES - 1);
    pick = $urandom_range(0, 99);
    if (pick < 60) rn_now[k] += $urandom_range(0, 400);
    else if (pick < 75) rn_now[k] += $urandom_range(0, 30);
    else if (pick < 85) rn_now[k] += $urandom_range(3500, 4000);
    else if (pick < 93) rn_now[k] -= $urandom_range(1, 500);
    else rn_now[k] = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      rn_cnt[k][$urandom_range(0, 3)] += $urandom_range(1, 8);
    end else if (pick < 28) begin
      for (int j = 0; j < 4; j++) rn_cnt[k][j] = {$urandom, $urandom};
    end
    p.device = k[3:0];
    p.now_secs = rn_now[k];
    p.stats_ok = ($urandom_range(0, 99) < 90);
    if (p.stats_ok) begin
      p.read_count = rn_cnt[k][0];
      p.read_sector_count = rn_cnt[k][1];
      p.write_count = rn_cnt[k][2];
      p.write_sector_count = rn_cnt[k][3];
    end else begin
      p.read_count = {$urandom, $urandom};
      p.read_sector_count = {$urandom, $urandom};
      p.write_count = {$urandom, $urandom};
      p.write_sector_count = {$urandom, $urandom};
    end
    p.cache_state = ($urandom_range(0, 99) < 85) ? 2'($urandom_range(0, 1))
                                                 : 2'($urandom_range(2, 3));
    p.spin_status = ($urandom_range(0, 99) < 40) ? SPIN_STANDBY
                                                 : 2'($urandom_range(1, 3));
    edge_mb = {32'd0, cf_minwb} << MB_SHIFT;
    pick = $urandom_range(0, 99);
    if (pick < 30) p.dirty_size = '0;
    else if (pick < 65)
      p.dirty_size = (64'($urandom_range(0, 160)) << MB_SHIFT) |
                     64'($urandom_range(0, 32'(MB - 1)));
    else if (pick < 80)
      p.dirty_size = edge_mb - MB + 64'($urandom_range(0, 32'(2 * MB)));
    else p.dirty_size = {$urandom, $urandom};
    return p;
  endfunction

  // Offer one poll beat; queue its decision once the block takes it
  task automatic offer_poll(input in_t poll, input bit typed, input out_t want);
    out_t got;
    while (!calm && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= poll;
    do @(posedge clk_i); while (in_stall);
    got = decide_action(poll);
    decisions_q.push_back(typed ? want : got);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    case (idx)
      CFG_DELAY:   cf_delay = val;
      CFG_MIN_WB:  cf_minwb = val;
      CFG_MAX_CYC: cf_maxcyc = val[15:0];
      CFG_RATE:    cf_rate = val;
      CFG_DRY_RUN: cf_dry = val[0];
      default: ;
    endcase
  endtask

  // Reprogram only once every decision in flight has come out
  task automatic program_policy(input logic [31:0] delay, input logic [31:0] minwb,
                                input logic [31:0] maxcyc, input logic [31:0] rate,
                                input logic [31:0] dry);
    in_valid <= 1'b0;
    while (decisions_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    write_reg(CFG_DELAY, delay);
    write_reg(CFG_MIN_WB, minwb);
    write_reg(CFG_MAX_CYC, maxcyc);
    write_reg(CFG_RATE, rate);
    write_reg(CFG_DRY_RUN, dry);
    cfg_we <= 1'b0;
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 7);
    end
  end

  // Result beats against the oldest queued decision
  always @(posedge clk_i) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (decisions_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result beat with no poll pending: %p", out_data);
      end else begin
        want = decisions_q.pop_front();
        if (want.device_out !== out_data.device_out || want.action !== out_data.action ||
            want.writeback_write !== out_data.writeback_write ||
            want.issue_spindown !== out_data.issue_spindown ||
            want.set_rate !== out_data.set_rate || want.idle_time !== out_data.idle_time ||
            want.dirty_mib !== out_data.dirty_mib ||
            want.cycles_used !== out_data.cycles_used) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: want dev %0d act %0d wb %0d iss %0b rate %0b idle %0d mb %0d cyc %0d",
                     want.device_out, want.action, want.writeback_write,
                     want.issue_spindown, want.set_rate, want.idle_time, want.dirty_mib,
                     want.cycles_used, "\n          got  dev %0d act %0d wb %0d iss %0b",
                     out_data.device_out, out_data.action, out_data.writeback_write,
                     out_data.issue_spindown, " rate %0b idle %0d mb %0d cyc %0d",
                     out_data.set_rate, out_data.idle_time, out_data.dirty_mib,
                     out_data.cycles_used);
        end
      end
    end
  end

  // Watchdog: too long without any beat on either side
  always @(posedge clk_i) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", quiet_cycles);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    row_t        rows [$];
    int unsigned ph;
    int unsigned n;
    repeat (3) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Directed polls under the reset policy
    // disk 0: first poll, spin-down, flush, paused, activity, writeback on
    rows.push_back(row_t'{poll_of(4'd0, 32'd1000, 64'd0, 2'd0, 1'b1, 64'd1, 64'd2, 64'd3,
                                  64'd4, 2'd1), 1'b1,
                          result_of(4'd0, ACT_IDLE, WB_NONE, 1'b0, 1'b0, 31'd0, 44'd0, 16'd0)});
    rows.push_back(row_t'{poll_of(4'd0, 32'd1400, 64'd0, 2'd0, 1'b1, 64'd1, 64'd2, 64'd3,
                                  64'd4, 2'd1), 1'b1,
                          result_of(4'd0, ACT_SPINDOWN, WB_OFF, 1'b1, 1'b0, 31'd400, 44'd0,
                                    16'd1)});
    rows.push_back(row_t'{poll_of(4'd0, 32'd1500, 64 * MB, 2'd1, 1'b1, 64'd1, 64'd2, 64'd3,
                                  64'd4, SPIN_STANDBY), 1'b1,
                          result_of(4'd0, ACT_FLUSH, WB_ON, 1'b0, 1'b0, 31'd500, 44'd64,
                                    16'd2)});
    rows.push_back(row_t'{poll_of(4'd0, 32'd1600, 64 * MB - 1, 2'd1, 1'b1, 64'd1, 64'd2,
                                  64'd3, 64'd4, SPIN_STANDBY), 1'b1,
                          result_of(4'd0, ACT_PAUSED, WB_OFF, 1'b0, 1'b0, 31'd100, 44'd63,
                                    16'd2)});
    rows.push_back(row_t'{poll_of(4'd0, 32'd1700, 64'd1, 2'd0, 1'b1, 64'd5, 64'd2, 64'd3,
                                  64'd4, 2'd2), 1'b1,
                          result_of(4'd0, ACT_IDLE, WB_NONE, 1'b0, 1'b0, 31'd0, 44'd0, 16'd2)});
    rows.push_back(row_t'{poll_of(4'd0, 32'd1800, 2 * MB, 2'd0, 1'b1, 64'd5, 64'd2, 64'd3,
                                  64'd4, 2'd3), 1'b1,
                          result_of(4'd0, ACT_WB_SPIN, WB_ON, 1'b0, 1'b0, 31'd100, 44'd2,
                                    16'd2)});
    // clock steps back, then the hour window rolls over
    rows.push_back(row_t'{poll_of(4'd0, 32'd900, 64'd0, 2'd0, 1'b1, 64'd5, 64'd2, 64'd3,
                                  64'd4, 2'd1), 1'b0, '0});
    rows.push_back(row_t'{poll_of(4'd0, 32'd4500, 64'd0, 2'd0, 1'b1, 64'd5, 64'd2, 64'd3,
                                  64'd4, 2'd1), 1'b0, '0});
    rows.push_back(row_t'{poll_of(4'd0, 32'd4600, 64'd0, 2'd0, 1'b1, 64'd5, 64'd2, 64'd3,
                                  64'd4, 2'd1), 1'b0, '0});
    // use up the hourly budget, then the flush is deferred
    for (n = 1; n <= 3; n++)
      rows.push_back(row_t'{poll_of(4'd0, 32'd4600 + n, 64 * MB, 2'd1, 1'b1, 64'd5, 64'd2,
                                    64'd3, 64'd4, SPIN_STANDBY), 1'b0, '0});
    rows.push_back(row_t'{poll_of(4'd0, 32'd4604, 64 * MB, 2'd1, 1'b1, 64'd5, 64'd2, 64'd3,
                                  64'd4, SPIN_STANDBY), 1'b1,
                          result_of(4'd0, ACT_DEFER, WB_NONE, 1'b0, 1'b0, 31'd1, 44'd64,
                                    16'd4)});
    // counters not readable: garbage must be ignored
    rows.push_back(row_t'{poll_of(4'd0, 32'd4700, 64'd0, 2'd0, 1'b0, ALL1, 64'd0, ALL1,
                                  64'd0, 2'd1), 1'b0, '0});
    // disk 1: skipped first poll, time wrap, longest idle, all-zero counters
    rows.push_back(row_t'{poll_of(4'd1, 32'hFFFF_FFFF, ALL1, 2'd2, 1'b1, 64'd0, 64'd0, 64'd0,
                                  64'd0, 2'd1), 1'b1,
                          result_of(4'd1, ACT_SKIP, WB_NONE, 1'b0, 1'b0, 31'd0,
                                    44'hFFF_FFFF_FFFF, 16'd0)});
    rows.push_back(row_t'{poll_of(4'd1, 32'd0, 64'd0, 2'd3, 1'b1, 64'd0, 64'd0, 64'd0,
                                  64'd0, 2'd1), 1'b1,
                          result_of(4'd1, ACT_SKIP, WB_NONE, 1'b0, 1'b0, 31'd0, 44'd0, 16'd0)});
    rows.push_back(row_t'{poll_of(4'd1, 32'd0, 64'd0, 2'd0, 1'b1, ALL1, ALL1, ALL1, ALL1,
                                  2'd1), 1'b0, '0});
    rows.push_back(row_t'{poll_of(4'd1, 32'h7FFF_FFFE, 64'd0, 2'd0, 1'b1, ALL1, ALL1, ALL1,
                                  ALL1, 2'd1), 1'b1,
                          result_of(4'd1, ACT_SPINDOWN, WB_OFF, 1'b1, 1'b0, 31'h7FFF_FFFF,
                                    44'd0, 16'd1)});
    rows.push_back(row_t'{poll_of(4'd1, 32'h8000_0000, ALL1, 2'd1, 1'b1, 64'd0, 64'd0, 64'd0,
                                  64'd0, SPIN_STANDBY), 1'b0, '0});
    rows.push_back(row_t'{poll_of(4'd15, 32'd1234, 64'd0, 2'd2, 1'b0, 64'd0, 64'd0, 64'd0,
                                  64'd0, SPIN_STANDBY), 1'b1,
                          result_of(4'd15, ACT_SKIP, WB_NONE, 1'b0, 1'b0, 31'd0, 44'd0,
                                    16'd0)});
    foreach (rows[i]) offer_poll(rows[i].poll, rows[i].typed, rows[i].want);

    // Random polls over a series of policy settings
    foreach (rn_now[k]) begin
      rn_now[k] = $urandom;
      for (int j = 0; j < 4; j++) rn_cnt[k][j] = {$urandom, $urandom};
    end
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: program_policy(32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd1);
        1: program_policy(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_FFFF, 32'd1, 32'd0);
        2: program_policy($urandom, $urandom, $urandom, $urandom, $urandom);
        default: program_policy($urandom_range(0, 600), $urandom_range(1, 100),
                                $urandom_range(1, 6),
                                $urandom_range(0, 1) ? $urandom : 32'd0,
                                $urandom_range(0, 1));
      endcase
      calm = (ph == 4);
      for (n = 0; n < PHASE_POLLS; n++) begin
        if ((ph == 1 || ph == 6) && n == 20) hold_reqs++;
        offer_poll(random_poll(), 1'b0, '0);
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (decisions_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && decisions_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/dsp_pkg.sv
rtl/core/disk_spindown_policy_top.sv
tb/disk_spindown_policy_top_tb.sv
